// ----- hw/rtl/lgr_pkg.sv -----
`default_nettype none

package lgr_pkg;

  // Width of a row on the stream ports
  localparam int DATA_W = 64;

  // Width of the row_length register
  localparam int LEN_W = 7;

  // Default number of cells held per row
  localparam int ROW_WIDTH_DEF = 64;

endpackage

`default_nettype wire

// ----- hw/rtl/lgr_cell.sv -----
`default_nettype none

module lgr_cell (
  input  logic [2:0] above,
  input  logic [2:0] here,
  input  logic [2:0] below,
  output logic       next
);

  logic [3:0] count;

  // The center bit of the current row is the cell itself, not a neighbor
  assign count = 4'(above[0]) + 4'(above[1]) + 4'(above[2])
               + 4'(here[0])                  + 4'(here[2])
               + 4'(below[0]) + 4'(below[1]) + 4'(below[2]);

  assign next = (count == 4'd3) || (here[1] && (count == 4'd2));

endmodule

`default_nettype wire

// ----- hw/rtl/lgr_row.sv -----
`default_nettype none

module lgr_row #(
  parameter int ROW_WIDTH = 64
) (
  input  logic [ROW_WIDTH-1:0]      above,
  input  logic [ROW_WIDTH-1:0]      here,
  input  logic [ROW_WIDTH-1:0]      below,
  input  logic [ROW_WIDTH-1:0]      mask,
  output logic [lgr_pkg::DATA_W-1:0] next_row
);

  import lgr_pkg::*;

  logic [ROW_WIDTH+1:0] above_ext;
  logic [ROW_WIDTH+1:0] here_ext;
  logic [ROW_WIDTH+1:0] below_ext;
  logic [ROW_WIDTH-1:0] lane_next;

  // Pad both edges with dead cells; cells past the row length read as dead
  assign above_ext = {1'b0, above & mask, 1'b0};
  assign here_ext  = {1'b0, here & mask, 1'b0};
  assign below_ext = {1'b0, below & mask, 1'b0};

  for (genvar i = 0; i < ROW_WIDTH; i++) begin : g_lane
    lgr_cell u_cell (
      .above (above_ext[i+2:i]),
      .here  (here_ext[i+2:i]),
      .below (below_ext[i+2:i]),
      .next  (lane_next[i])
    );
  end

  // Merge lanes: drop unused cells and widen to the port row
  assign next_row = DATA_W'(lane_next & mask);

endmodule

`default_nettype wire

// ----- hw/rtl/life_generation_row_engine.sv -----
`default_nettype none

// Conway Life (B3/S23) generation engine. The grid arrives one row per
// transfer on s_*, top row first, with tlast on the final row. The block
// holds the two most recent rows and, for each incoming row but the first,
// sends on m_* the next generation of the row above it; the final row also
// sends its own next generation with tlast set, so a one-row frame gives one
// transfer. Off-grid cells and cells at or above row_length (written on
// cfg_*, reset 64) are dead and come out as 0. One row is taken every
// cycle while m_* is free and no result is pending; a final row that also
// completes a held row makes two transfers, the second via one pending slot.
// Write row_length only while no frame is in flight.
module life_generation_row_engine #(
  parameter int ROW_WIDTH = lgr_pkg::ROW_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [lgr_pkg::DATA_W-1:0] s_tdata,   // row_cells[63:0]
  input  logic                       s_tlast,   // last_row
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [lgr_pkg::DATA_W-1:0] m_tdata,   // next_row[63:0]
  output logic                       m_tlast,   // frame_done
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [lgr_pkg::LEN_W-1:0]  cfg_data   // row_length[6:0]
);

  import lgr_pkg::*;

  logic [ROW_WIDTH-1:0] mask;
  logic [ROW_WIDTH-1:0] mask_next;
  logic [ROW_WIDTH-1:0] upper_row;
  logic [ROW_WIDTH-1:0] middle_row;
  logic                 middle_valid;
  logic [ROW_WIDTH-1:0] row_in;
  logic [ROW_WIDTH-1:0] upper_eff;

  logic [DATA_W-1:0]    res_mid;
  logic [DATA_W-1:0]    res_last;

  logic                 out_valid;
  logic [DATA_W-1:0]    out_data;
  logic                 out_last;
  logic                 pend_valid;
  logic [DATA_W-1:0]    pend_data;

  logic                 out_free;
  logic                 accept;

  assign cfg_ready = 1'b1;

  for (genvar i = 0; i < ROW_WIDTH; i++) begin : g_mask
    assign mask_next[i] = (cfg_data > LEN_W'(i));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= '1;
    end else if (cfg_valid) begin
      mask <= mask_next;
    end
  end

  assign row_in    = s_tdata[ROW_WIDTH-1:0] & mask;
  // Row above the incoming one once the held row has been processed
  assign upper_eff = middle_valid ? middle_row : '0;

  lgr_row #(.ROW_WIDTH(ROW_WIDTH)) u_row_mid (
    .above    (upper_row),
    .here     (middle_row),
    .below    (row_in),
    .mask     (mask),
    .next_row (res_mid)
  );

  lgr_row #(.ROW_WIDTH(ROW_WIDTH)) u_row_last (
    .above    (upper_eff),
    .here     (row_in),
    .below    ('0),
    .mask     (mask),
    .next_row (res_last)
  );

  assign out_free = !out_valid || m_tready;
  assign s_tready = out_free && !pend_valid;
  assign accept   = s_tvalid && s_tready;

  // Row history
  always_ff @(posedge clk) begin
    if (rst) begin
      upper_row    <= '0;
      middle_row   <= '0;
      middle_valid <= 1'b0;
    end else if (accept) begin
      if (s_tlast) begin
        upper_row    <= '0;
        middle_row   <= '0;
        middle_valid <= 1'b0;
      end else begin
        upper_row    <= upper_eff;
        middle_row   <= row_in;
        middle_valid <= 1'b1;
      end
    end
  end

  // Output register with one pending slot for the second result of a final row
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else if (pend_valid && out_free) begin
      out_valid  <= 1'b1;
      pend_valid <= 1'b0;
    end else if (accept) begin
      out_valid  <= middle_valid || s_tlast;
      pend_valid <= middle_valid && s_tlast;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pend_valid && out_free) begin
      out_data <= pend_data;
      out_last <= 1'b1;
    end else if (accept) begin
      if (middle_valid) begin
        out_data <= res_mid;
        out_last <= 1'b0;
      end else begin
        out_data <= res_last;
        out_last <= 1'b1;
      end
      pend_data <= res_last;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;
  assign m_tlast  = out_last;

endmodule

`default_nettype wire

// ----- dv/life_generation_row_engine_tb.sv -----
`default_nettype none

module life_generation_row_engine_tb;

  localparam int W = lgr_pkg::DATA_W;

  typedef struct packed {
    logic [W-1:0] next_row;
    logic         frame_done;
  } gen_result_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     s_tvalid = 1'b0;
  logic                     s_tready;
  logic [W-1:0]             s_tdata = '0;     // row_cells[63:0]
  logic                     s_tlast = 1'b0;   // last_row
  logic                     m_tvalid;
  logic                     m_tready = 1'b0;
  logic [W-1:0]             m_tdata;          // next_row[63:0]
  logic                     m_tlast;          // frame_done
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [lgr_pkg::LEN_W-1:0] cfg_data = '0;   // row_length[6:0]

  // Predictor state
  logic [lgr_pkg::LEN_W-1:0] row_len = 7'd64;
  logic [W-1:0]              above_row = '0;
  logic [W-1:0]              held_row = '0;
  logic                      above_live = 1'b0;
  logic                      row_held = 1'b0;

  gen_result_t next_gen_q[$];
  gen_result_t want;
  int          fail_count = 0;
  int          src_idle = 0;
  int          snk_idle = 0;
  int          stall_req = 0;
  int          stall_left = 0;

  life_generation_row_engine uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [W-1:0] cells_in_use_mask();
    int len;
    len = (row_len > 7'd64) ? 64 : int'(row_len);
    if (len >= 64) return '1;
    return (64'd1 << len) - 64'd1;
  endfunction

  function automatic int unsigned cell_at(input logic [W-1:0] r, input int pos);
    if (pos < 0 || pos > W - 1) return 0;
    return int'(r[pos]);
  endfunction

  function automatic logic [W-1:0] life_next(input logic [W-1:0] a, input logic [W-1:0] h,
                                             input logic [W-1:0] b, input logic [W-1:0] m);
    logic [W-1:0] res;
    int unsigned  n;
    res = '0;
    a = a & m;
    h = h & m;
    b = b & m;
    for (int i = 0; i < W; i++) begin
      n = cell_at(a, i - 1) + cell_at(a, i) + cell_at(a, i + 1)
        + cell_at(h, i - 1) + cell_at(h, i + 1)
        + cell_at(b, i - 1) + cell_at(b, i) + cell_at(b, i + 1);
      if (n == 3 || (h[i] && n == 2)) res[i] = 1'b1;
    end
    return res & m;
  endfunction

  // Advance the predictor by one accepted row and queue the generations it completes
  function automatic void predict_generation(input logic [W-1:0] cells, input logic last);
    logic [W-1:0] m;
    logic [W-1:0] r;
    m = cells_in_use_mask();
    r = cells & m;
    if (row_held) begin
      next_gen_q.push_back('{life_next(above_live ? above_row : '0, held_row, r, m), 1'b0});
      above_row = held_row;
      above_live = 1'b1;
    end else begin
      above_row = '0;
      above_live = 1'b0;
    end
    held_row = r;
    row_held = 1'b1;
    if (last) begin
      next_gen_q.push_back('{life_next(above_live ? above_row : '0, held_row, '0, m), 1'b1});
      above_row = '0;
      held_row = '0;
      above_live = 1'b0;
      row_held = 1'b0;
    end
  endfunction

  function automatic void note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%0t: mismatch: %s", $realtime, msg);
  endfunction

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (next_gen_q.size() == 0) begin
        note_failure($sformatf("unexpected transfer next_row=%h frame_done=%b",
                               m_tdata, m_tlast));
      end else begin
        want = next_gen_q.pop_front();
        if (m_tdata !== want.next_row)
          note_failure($sformatf("next_row expected %h got %h", want.next_row, m_tdata));
        if (m_tlast !== want.frame_done)
          note_failure($sformatf("frame_done expected %b got %b", want.frame_done, m_tlast));
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off on request
  always @(negedge clk) begin
    if (stall_req > 0) begin
      stall_left = stall_req;
      stall_req = 0;
    end
    if (stall_left > 0) begin
      m_tready = 1'b0;
      stall_left--;
    end else begin
      m_tready = ($urandom_range(99) >= snk_idle);
    end
  end

  task automatic send_row(input logic [W-1:0] cells, input logic last);
    while ($urandom_range(99) < src_idle) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata = cells;
    s_tlast = last;
    do @(posedge clk); while (!s_tready);
    predict_generation(cells, last);
    @(negedge clk);
  endtask

  // Drop valid, wait for every queued generation, then let the pipeline settle
  task automatic drain();
    s_tvalid = 1'b0;
    while (next_gen_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_row_length(input logic [lgr_pkg::LEN_W-1:0] len);
    drain();
    cfg_valid = 1'b1;
    cfg_data = len;
    do @(posedge clk); while (!cfg_ready);
    row_len = len;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic [W-1:0] random_row();
    case ($urandom_range(3))
      0: return {$urandom, $urandom};
      1: return {$urandom, $urandom} & {$urandom, $urandom};
      2: return {$urandom, $urandom} | {$urandom, $urandom};
      default: return {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
    endcase
  endfunction

  task automatic send_random_frame(input int rows);
    for (int i = 0; i < rows; i++) send_row(random_row(), i == rows - 1);
  endtask

  function automatic logic [lgr_pkg::LEN_W-1:0] pick_row_length();
    case ($urandom_range(9))
      0: return 7'd0;
      1: return 7'd1;
      2: return 7'd2;
      3: return 7'd63;
      4: return 7'd64;
      5: return 7'd65;
      6: return 7'd127;
      default: return 7'($urandom_range(3, 64));
    endcase
  endfunction

  // Single-row frames, corners, alternating rows and a glider at full width
  task automatic test_directed_patterns();
    src_idle = 0;
    snk_idle = 0;
    send_row('1, 1'b1);
    send_row('0, 1'b1);
    send_row(64'h8000_0000_0000_0001, 1'b0);
    send_row(64'hC000_0000_0000_0003, 1'b0);
    send_row(64'h8000_0000_0000_0001, 1'b1);
    send_row(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
    send_row(64'h5555_5555_5555_5555, 1'b0);
    send_row('1, 1'b1);
    send_row(64'h2, 1'b0);
    send_row(64'h4, 1'b0);
    send_row(64'h7, 1'b0);
    send_row(64'h0, 1'b0);
    send_row(64'h0, 1'b1);
    drain();
  endtask

  // Short rows, zero length and lengths past the row width
  task automatic test_row_length_extremes();
    logic [lgr_pkg::LEN_W-1:0] lens[7] = '{7'd1, 7'd2, 7'd0, 7'd63, 7'd65, 7'd127, 7'd64};
    foreach (lens[i]) begin
      write_row_length(lens[i]);
      send_row('1, 1'b0);
      send_row({$urandom, $urandom}, 1'b1);
    end
    drain();
  endtask

  task automatic test_random_frames(input int src, input int snk, input int n_rows);
    int sent;
    sent = 0;
    src_idle = src;
    snk_idle = snk;
    while (sent < n_rows) begin
      int rows;
      if ($urandom_range(7) == 0) write_row_length(pick_row_length());
      rows = ($urandom_range(3) == 0) ? 1 : $urandom_range(2, 10);
      send_random_frame(rows);
      sent += rows;
    end
    drain();
  endtask

  // Hold the output off long enough that the block fills and stalls its input
  task automatic test_output_holdoff();
    write_row_length(7'd64);
    src_idle = 0;
    snk_idle = 0;
    stall_req = 200;
    for (int f = 0; f < 6; f++) send_random_frame(f + 2);
    drain();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed_patterns();
    test_row_length_extremes();
    test_random_frames(22, 76, 500);
    test_random_frames(76, 22, 500);
    test_random_frames(0, 0, 500);
    test_output_holdoff();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && next_gen_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

`default_nettype wire

// ----- life_generation_row_engine.f -----
hw/rtl/lgr_pkg.sv
hw/rtl/lgr_cell.sv
hw/rtl/lgr_row.sv
hw/rtl/life_generation_row_engine.sv
dv/life_generation_row_engine_tb.sv
